### hw/rtl/dda_pkg.sv
// Package for the disk drive adapter register block.
// Types, constants and helpers shared by dda_regs and the top level.
// No dependencies.
package dda_pkg;

  localparam int unsigned SIDES      = 8;
  localparam int unsigned SIDE_BYTES = 65536;
  localparam int unsigned SIDE_W     = $clog2(SIDES);
  localparam int unsigned POS_W      = $clog2(SIDE_BYTES);
  localparam int unsigned ADDR_W     = SIDE_W + POS_W;

  localparam logic [15:0] HEAD_READ_LIMIT  = 16'd64999;
  localparam logic [15:0] HEAD_WRITE_LIMIT = 16'd65500;
  localparam logic [7:0]  READ_DELAY       = 8'd150;
  localparam logic [7:0]  SEEK_DELAY       = 8'd200;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_READ   = 3'd2,
    OP_INSERT = 3'd3,
    OP_SELECT = 3'd4,
    OP_LOAD   = 3'd5
  } op_t;

  localparam logic [4:0] WR_RELOAD_LO = 5'h00;
  localparam logic [4:0] WR_RELOAD_HI = 5'h01;
  localparam logic [4:0] WR_TIMER_CTL = 5'h02;
  localparam logic [4:0] WR_ENABLE    = 5'h03;
  localparam logic [4:0] WR_DATA      = 5'h04;
  localparam logic [4:0] WR_CONTROL   = 5'h05;
  localparam logic [4:0] WR_EXTERNAL  = 5'h06;
  localparam logic [4:0] RD_IRQ       = 5'h10;
  localparam logic [4:0] RD_DATA      = 5'h11;
  localparam logic [4:0] RD_STATUS    = 5'h12;
  localparam logic [4:0] RD_EXTERNAL  = 5'h13;

  typedef struct packed {
    logic [15:0] load_addr;
    logic [2:0]  load_side;
    logic        debug_peek;
    logic [7:0]  open_bus;
    logic [9:0]  tick_cycles;
    logic [7:0]  write_data;
    logic [4:0]  reg_offset;
    logic [2:0]  opcode;
  } item_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       rd_mem;
    logic       rd_latch;
    logic       timer_irq;
    logic       disk_irq;
    logic       mirror_select;
    logic       disk_written;
    logic       disk_present;
    logic       refused;
  } result_t;

  function automatic logic [2:0] next_side(input logic [2:0] sel, input logic [3:0] cnt);
    logic [3:0] n;
    logic [3:0] v;
    n = (cnt == 4'd0) ? 4'd1 : ((cnt > 4'(SIDES)) ? 4'(SIDES) : cnt);
    v = {1'b0, sel} + 4'd1;
    for (int i = 0; i < 4; i++) begin
      if (v >= n) v = v - n;
    end
    return {1'b0, v[1:0]};
  endfunction

endpackage

### hw/rtl/dda_ram.sv
// Single-port synchronous RAM holding the disk image.
// Read data registered. No dependencies.
module dda_ram #(
  parameter int unsigned AW = 19,
  parameter int unsigned DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    if (re) rdata <= mem[addr];
  end

endmodule

### hw/rtl/dda_regs.sv
// Register file and update logic of the adapter: timers, latches, head pointer.
// Issues image memory requests. Depends on dda_pkg.
module dda_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  dda_pkg::item_t     item,
  input  logic [3:0]         side_count,
  output dda_pkg::mem_req_t  req,
  output dda_pkg::result_t   res
);

  logic [15:0] timer_count, timer_count_next;
  logic [15:0] timer_reload, timer_reload_next;
  logic        timer_repeat, timer_repeat_next;
  logic [7:0]  enable_reg, enable_reg_next;
  logic [7:0]  control_reg, control_reg_next;
  logic [7:0]  external_latch, external_latch_next;
  logic [15:0] head_position, head_position_next;
  logic [7:0]  transfer_timer, transfer_timer_next;
  logic [1:0]  skip_count, skip_count_next;
  logic        inserted_present, inserted_present_next;
  logic [2:0]  inserted_side, inserted_side_next;
  logic [2:0]  selected_side, selected_side_next;
  logic [1:0]  irq_flags, irq_flags_next;
  logic        modified_flag, modified_flag_next;

  always_comb begin
    logic [7:0] v;
    v = item.write_data;
    timer_count_next      = timer_count;
    timer_reload_next     = timer_reload;
    timer_repeat_next     = timer_repeat;
    enable_reg_next       = enable_reg;
    control_reg_next      = control_reg;
    external_latch_next   = external_latch;
    head_position_next    = head_position;
    transfer_timer_next   = transfer_timer;
    skip_count_next       = skip_count;
    inserted_present_next = inserted_present;
    inserted_side_next    = inserted_side;
    selected_side_next    = selected_side;
    irq_flags_next        = irq_flags;
    modified_flag_next    = modified_flag;
    req                   = '0;
    res                   = '0;
    case (item.opcode)
      dda_pkg::OP_TICK: begin
        if (timer_count != 16'd0) begin
          if ({6'd0, item.tick_cycles} >= timer_count) begin
            timer_count_next = timer_repeat ? timer_reload : 16'd0;
            irq_flags_next[0] = 1'b1;
          end else begin
            timer_count_next = timer_count - {6'd0, item.tick_cycles};
          end
        end
        if (transfer_timer != 8'd0) begin
          if (item.tick_cycles >= {2'd0, transfer_timer}) begin
            transfer_timer_next = 8'd0;
            if (control_reg[7]) irq_flags_next[1] = 1'b1;
          end else begin
            transfer_timer_next = transfer_timer - item.tick_cycles[7:0];
          end
        end
      end
      dda_pkg::OP_WRITE: begin
        case (item.reg_offset)
          dda_pkg::WR_RELOAD_LO: begin
            if (enable_reg[0]) timer_reload_next[7:0] = v;
          end
          dda_pkg::WR_RELOAD_HI: begin
            if (enable_reg[0]) timer_reload_next[15:8] = v;
          end
          dda_pkg::WR_TIMER_CTL: begin
            irq_flags_next[0] = 1'b0;
            if (enable_reg[0]) begin
              if (v[1]) timer_count_next = timer_reload;
              timer_repeat_next = v[0];
            end
          end
          dda_pkg::WR_ENABLE: enable_reg_next = v;
          dda_pkg::WR_DATA: begin
            if (inserted_present && !control_reg[2] && enable_reg[0] &&
                head_position < dda_pkg::HEAD_WRITE_LIMIT) begin
              if (skip_count != 2'd0) begin
                skip_count_next = skip_count - 2'd1;
              end else if (head_position >= 16'd2) begin
                modified_flag_next = 1'b1;
                req.we    = 1'b1;
                req.addr  = {inserted_side, head_position - 16'd2};
                req.wdata = v;
              end
            end
          end
          dda_pkg::WR_CONTROL: begin
            irq_flags_next[1] = 1'b0;
            if (inserted_present) begin
              if (!v[6] && control_reg[6] && !v[4]) begin
                transfer_timer_next = dda_pkg::SEEK_DELAY;
                head_position_next = (head_position >= 16'd2) ? head_position - 16'd2 : 16'd0;
              end
              if (!v[2]) skip_count_next = 2'd2;
              if (v[1]) begin
                head_position_next  = 16'd0;
                transfer_timer_next = dda_pkg::SEEK_DELAY;
              end
              if (v[6]) transfer_timer_next = dda_pkg::SEEK_DELAY;
            end
            control_reg_next = v;
          end
          dda_pkg::WR_EXTERNAL: external_latch_next = v;
          default: ;
        endcase
      end
      dda_pkg::OP_READ: begin
        case (item.reg_offset)
          dda_pkg::RD_IRQ: begin
            res.read_data = {6'd0, irq_flags};
            if (!item.debug_peek) irq_flags_next = 2'd0;
          end
          dda_pkg::RD_DATA: begin
            res.rd_latch = 1'b1;
            if (inserted_present) begin
              res.rd_mem = 1'b1;
              req.re     = 1'b1;
              req.addr   = {inserted_side, head_position};
              if (!item.debug_peek) begin
                if (head_position < dda_pkg::HEAD_READ_LIMIT)
                  head_position_next = head_position + 16'd1;
                transfer_timer_next = dda_pkg::READ_DELAY;
                irq_flags_next[1] = 1'b0;
              end
            end
          end
          dda_pkg::RD_STATUS: begin
            res.read_data = {item.open_bus[7:3], !inserted_present,
                             !inserted_present || !control_reg[0] || control_reg[1],
                             !inserted_present};
          end
          dda_pkg::RD_EXTERNAL: res.read_data = {external_latch[7], 7'd0};
          default: res.read_data = item.open_bus;
        endcase
      end
      dda_pkg::OP_INSERT: begin
        if (!inserted_present) begin
          inserted_present_next = 1'b1;
          inserted_side_next    = selected_side;
        end else begin
          inserted_present_next = 1'b0;
        end
      end
      dda_pkg::OP_SELECT: begin
        if (inserted_present) res.refused = 1'b1;
        else selected_side_next = dda_pkg::next_side(selected_side, side_count);
      end
      dda_pkg::OP_LOAD: begin
        req.we    = 1'b1;
        req.addr  = {item.load_side, item.load_addr};
        req.wdata = v;
      end
      default: ;
    endcase
    if (!accept) begin
      req.we = 1'b0;
      req.re = 1'b0;
    end
    res.timer_irq     = irq_flags_next[0];
    res.disk_irq      = irq_flags_next[1];
    res.mirror_select = !control_reg_next[3];
    res.disk_written  = modified_flag_next;
    res.disk_present  = inserted_present_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_count      <= '0;
      timer_reload     <= '0;
      timer_repeat     <= 1'b0;
      enable_reg       <= '0;
      control_reg      <= '0;
      external_latch   <= '0;
      head_position    <= '0;
      transfer_timer   <= '0;
      skip_count       <= '0;
      inserted_present <= 1'b1;
      inserted_side    <= '0;
      selected_side    <= '0;
      irq_flags        <= '0;
      modified_flag    <= 1'b0;
    end else if (accept) begin
      timer_count      <= timer_count_next;
      timer_reload     <= timer_reload_next;
      timer_repeat     <= timer_repeat_next;
      enable_reg       <= enable_reg_next;
      control_reg      <= control_reg_next;
      external_latch   <= external_latch_next;
      head_position    <= head_position_next;
      transfer_timer   <= transfer_timer_next;
      skip_count       <= skip_count_next;
      inserted_present <= inserted_present_next;
      inserted_side    <= inserted_side_next;
      selected_side    <= selected_side_next;
      irq_flags        <= irq_flags_next;
      modified_flag    <= modified_flag_next;
    end
  end

endmodule

### hw/rtl/disk_drive_adapter_registers_top.sv
// Top level of the disk drive adapter register block.
// Instantiates dda_regs and dda_ram; depends on dda_pkg.
//
// One word in, one word out. Register state updates in the accept cycle; the
// image RAM read data and the result are registered into a holding stage at the
// accepting edge, and an output register follows it. A word is taken every cycle
// while m_axis_tready is high or the output register is empty, and a stall holds
// the holding stage. The single image RAM port is used at most once per word.
// No word is taken during reset. No clearing pass after reset.
module disk_drive_adapter_registers_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,     // side_count
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode, reg_offset, write_data, tick_cycles, open_bus, debug_peek,
  // load_side, load_addr, zero pad
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data, timer_irq, disk_irq, mirror_select, disk_written,
  // disk_present, refused, zero pad
  output logic [15:0] m_axis_tdata
);

  logic              accept;
  logic              advance;
  logic [3:0]        side_count;
  dda_pkg::item_t    item;
  dda_pkg::mem_req_t req;
  dda_pkg::result_t  res;
  dda_pkg::result_t  s1;
  logic              s1_valid;
  logic [7:0]        rdata;
  logic [7:0]        last_read_byte;
  logic [7:0]        rd_final;
  logic [15:0]       out_data;

  assign item          = s_axis_tdata[53:0];
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance && !rst;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) side_count <= 4'd1;
    else if (cfg_we) side_count <= cfg_wdata;
  end

  dda_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (item),
    .side_count (side_count),
    .req        (req),
    .res        (res)
  );

  dda_ram #(
    .AW (dda_pkg::ADDR_W),
    .DW (8)
  ) u_ram (
    .clk   (clk),
    .we    (req.we),
    .re    (req.re),
    .addr  (req.addr),
    .wdata (req.wdata),
    .rdata (rdata)
  );

  always_comb begin
    rd_final = s1.read_data;
    if (s1.rd_latch) rd_final = s1.rd_mem ? rdata : last_read_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      m_axis_tvalid  <= 1'b0;
      last_read_byte <= '0;
    end else if (advance) begin
      s1_valid      <= accept;
      m_axis_tvalid <= s1_valid;
      if (s1_valid && s1.rd_mem) last_read_byte <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) s1 <= res;
    if (advance && s1_valid)
      out_data <= {2'd0, s1.refused, s1.disk_present, s1.disk_written,
                   s1.mirror_select, s1.disk_irq, s1.timer_irq, rd_final};
  end

  assign m_axis_tdata = out_data;

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted word missing from holding stage");

  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1) && $stable(rdata)))
    else $error("holding stage changed while stalled");

  a_ram_read_ok: assert property (@(posedge clk) disable iff (rst)
    req.re |-> (accept && !req.we))
    else $error("image read issued without accept or with a write");

endmodule

### bench/tb_disk_drive_adapter_registers_top.sv
// Self-checking bench for disk_drive_adapter_registers_top: drives bus, tick, disk and
// image-load words, predicts each status word with a behavioral model and compares.
// Depends on dda_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_disk_drive_adapter_registers_top;

  typedef struct packed {
    logic       refused;
    logic       disk_present;
    logic       disk_written;
    logic       mirror_select;
    logic       disk_irq;
    logic       timer_irq;
    logic [7:0] read_data;
  } status_t;

  localparam int STALL_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  disk_drive_adapter_registers_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  logic [3:0]  m_sides;
  logic [15:0] m_tcount, m_treload, m_hpos;
  logic        m_trepeat, m_present, m_modified;
  logic [7:0]  m_enable, m_control, m_extlatch, m_xfer, m_lastbyte;
  logic [1:0]  m_skip, m_irq;
  logic [2:0]  m_ins_side, m_sel_side;
  logic [7:0]  image [bit [18:0]];

  status_t expected_status [$];
  int      errors = 0;
  int      idle_count = 0;
  bit      stall_en = 1'b1;
  bit      timed_out = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic bit image_known(input logic [2:0] sd, input logic [15:0] pos);
    return image.exists({sd, pos});
  endfunction

  task automatic model_reset();
    m_sides = 4'd1; m_tcount = '0; m_treload = '0; m_trepeat = 0;
    m_enable = '0; m_control = '0; m_extlatch = '0; m_hpos = '0; m_xfer = '0;
    m_skip = '0; m_present = 1; m_ins_side = '0; m_sel_side = '0;
    m_lastbyte = '0; m_irq = '0; m_modified = 0;
  endtask

  task automatic predict_status(input dda_pkg::item_t it);
    status_t s;
    int n;
    s = '0;
    case (it.opcode)
      dda_pkg::OP_TICK: begin
        if (m_tcount != 0) begin
          if ({6'd0, it.tick_cycles} >= m_tcount) begin
            m_tcount = m_trepeat ? m_treload : 16'd0;
            m_irq[0] = 1;
          end else m_tcount -= {6'd0, it.tick_cycles};
        end
        if (m_xfer != 0) begin
          if (it.tick_cycles >= {2'd0, m_xfer}) begin
            m_xfer = 0;
            if (m_control[7]) m_irq[1] = 1;
          end else m_xfer -= it.tick_cycles[7:0];
        end
      end
      dda_pkg::OP_WRITE: begin
        case (it.reg_offset)
          dda_pkg::WR_RELOAD_LO: if (m_enable[0]) m_treload[7:0] = it.write_data;
          dda_pkg::WR_RELOAD_HI: if (m_enable[0]) m_treload[15:8] = it.write_data;
          dda_pkg::WR_TIMER_CTL: begin
            m_irq[0] = 0;
            if (m_enable[0]) begin
              if (it.write_data[1]) m_tcount = m_treload;
              m_trepeat = it.write_data[0];
            end
          end
          dda_pkg::WR_ENABLE: m_enable = it.write_data;
          dda_pkg::WR_DATA: begin
            if (m_present && !m_control[2] && m_enable[0] &&
                m_hpos < dda_pkg::HEAD_WRITE_LIMIT) begin
              if (m_skip != 0) m_skip--;
              else if (m_hpos >= 2) begin
                m_modified = 1;
                image[{m_ins_side, 16'(m_hpos - 16'd2)}] = it.write_data;
              end
            end
          end
          dda_pkg::WR_CONTROL: begin
            m_irq[1] = 0;
            if (m_present) begin
              if (!it.write_data[6] && m_control[6] && !it.write_data[4]) begin
                m_xfer = dda_pkg::SEEK_DELAY;
                m_hpos = (m_hpos >= 2) ? m_hpos - 16'd2 : 16'd0;
              end
              if (!it.write_data[2]) m_skip = 2;
              if (it.write_data[1]) begin
                m_hpos = 0;
                m_xfer = dda_pkg::SEEK_DELAY;
              end
              if (it.write_data[6]) m_xfer = dda_pkg::SEEK_DELAY;
            end
            m_control = it.write_data;
          end
          dda_pkg::WR_EXTERNAL: m_extlatch = it.write_data;
          default: ;
        endcase
      end
      dda_pkg::OP_READ: begin
        case (it.reg_offset)
          dda_pkg::RD_IRQ: begin
            s.read_data = {6'd0, m_irq};
            if (!it.debug_peek) m_irq = 0;
          end
          dda_pkg::RD_DATA: begin
            if (m_present) begin
              m_lastbyte = image_known(m_ins_side, m_hpos) ? image[{m_ins_side, m_hpos}] : 8'd0;
              if (!it.debug_peek) begin
                if (m_hpos < dda_pkg::HEAD_READ_LIMIT) m_hpos++;
                m_xfer = dda_pkg::READ_DELAY;
                m_irq[1] = 0;
              end
            end
            s.read_data = m_lastbyte;
          end
          dda_pkg::RD_STATUS: begin
            s.read_data = it.open_bus & 8'hF8;
            if (!m_present) s.read_data |= 8'h05;
            if (!m_present || !m_control[0] || m_control[1]) s.read_data |= 8'h02;
          end
          dda_pkg::RD_EXTERNAL: s.read_data = m_extlatch & 8'h80;
          default: s.read_data = it.open_bus;
        endcase
      end
      dda_pkg::OP_INSERT: begin
        if (!m_present) begin
          m_present = 1;
          m_ins_side = m_sel_side;
        end else m_present = 0;
      end
      dda_pkg::OP_SELECT: begin
        if (m_present) s.refused = 1;
        else begin
          n = (m_sides == 0) ? 1 : (m_sides > dda_pkg::SIDES ? dda_pkg::SIDES : m_sides);
          m_sel_side = 3'(((m_sel_side + 1) % n) & 3);
        end
      end
      dda_pkg::OP_LOAD: image[{it.load_side, it.load_addr}] = it.write_data;
      default: ;
    endcase
    s.timer_irq = m_irq[0];
    s.disk_irq = m_irq[1];
    s.mirror_select = ~m_control[3];
    s.disk_written = m_modified;
    s.disk_present = m_present;
    expected_status.push_back(s);
  endtask

  task automatic send_word(input dda_pkg::item_t it);
    int gap;
    if (stall_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata <= {2'd0, it};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_status(it);
  endtask

  always @(posedge clk) begin
    status_t got, want;
    if (rst) m_axis_tready <= 1'b0;
    else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[13:0];
        if (expected_status.size() == 0) report_mismatch("unexpected word", got, 0);
        else begin
          want = expected_status.pop_front();
          if (got.read_data !== want.read_data)
            report_mismatch("read_data", got.read_data, want.read_data);
          if (got.timer_irq !== want.timer_irq)
            report_mismatch("timer_irq", got.timer_irq, want.timer_irq);
          if (got.disk_irq !== want.disk_irq)
            report_mismatch("disk_irq", got.disk_irq, want.disk_irq);
          if (got.mirror_select !== want.mirror_select)
            report_mismatch("mirror_select", got.mirror_select, want.mirror_select);
          if (got.disk_written !== want.disk_written)
            report_mismatch("disk_written", got.disk_written, want.disk_written);
          if (got.disk_present !== want.disk_present)
            report_mismatch("disk_present", got.disk_present, want.disk_present);
          if (got.refused !== want.refused)
            report_mismatch("refused", got.refused, want.refused);
        end
      end
      m_axis_tready <= stall_en ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_count <= 0;
    else if (expected_status.size() != 0 || s_axis_tvalid) begin
      idle_count <= idle_count + 1;
      if (idle_count >= STALL_LIMIT && !timed_out) begin
        timed_out = 1'b1;
        $display("tb_disk_drive_adapter_registers_top: done, errors");
        $finish;
      end
    end
  end

  function automatic dda_pkg::item_t make_word(input dda_pkg::op_t op, input logic [4:0] off,
                                               input logic [7:0] wd);
    dda_pkg::item_t it;
    it = '0;
    it.opcode = op;
    it.reg_offset = off;
    it.write_data = wd;
    it.open_bus = 8'($urandom);
    return it;
  endfunction

  task automatic send_op(input dda_pkg::op_t op, input logic [4:0] off, input logic [7:0] wd);
    send_word(make_word(op, off, wd));
  endtask

  task automatic send_tick(input logic [9:0] cyc);
    dda_pkg::item_t it;
    it = make_word(dda_pkg::OP_TICK, '0, '0);
    it.tick_cycles = cyc;
    send_word(it);
  endtask

  task automatic send_load(input logic [2:0] sd, input logic [15:0] pos, input logic [7:0] v);
    dda_pkg::item_t it;
    it = make_word(dda_pkg::OP_LOAD, '0, v);
    it.load_side = sd;
    it.load_addr = pos;
    send_word(it);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_side_count(input logic [3:0] v);
    drain();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_sides = v;
  endtask

  // make sure every byte from position 0 through upto on a side is written first
  task automatic fill_head_window(input logic [2:0] sd, input int upto);
    for (int p = 0; p <= upto; p++)
      if (!image_known(sd, 16'(p))) send_load(sd, 16'(p), 8'($urandom));
  endtask

  task automatic test_directed();
    send_load(3'd7, 16'hFFFF, 8'hFF);
    send_load(3'd0, 16'h0000, 8'h00);
    fill_head_window(3'd0, 8);
    send_op(dda_pkg::OP_WRITE, dda_pkg::WR_ENABLE, 8'h01);
    send_op(dda_pkg::OP_WRITE, dda_pkg::WR_RELOAD_LO, 8'h05);
    send_op(dda_pkg::OP_WRITE, dda_pkg::WR_RELOAD_HI, 8'h00);
    send_op(dda_pkg::OP_WRITE, dda_pkg::WR_TIMER_CTL, 8'h03);
    send_tick(10'd0);
    send_tick(10'd1023);
    send_op(dda_pkg::OP_READ, dda_pkg::RD_IRQ, 8'h00);
    send_op(dda_pkg::OP_WRITE, dda_pkg::WR_CONTROL, 8'hC1);
    send_tick(10'd1023);
    send_op(dda_pkg::OP_READ, dda_pkg::RD_DATA, 8'h00);
    send_op(dda_pkg::OP_READ, dda_pkg::RD_DATA, 8'h00);
    send_op(dda_pkg::OP_WRITE, dda_pkg::WR_CONTROL, 8'h80);
    send_op(dda_pkg::OP_WRITE, dda_pkg::WR_DATA, 8'h5A);
    send_op(dda_pkg::OP_WRITE, dda_pkg::WR_DATA, 8'h5A);
    send_op(dda_pkg::OP_WRITE, dda_pkg::WR_DATA, 8'hA5);
    send_op(dda_pkg::OP_WRITE, dda_pkg::WR_EXTERNAL, 8'h80);
    send_op(dda_pkg::OP_READ, dda_pkg::RD_EXTERNAL, 8'h00);
    send_op(dda_pkg::OP_READ, dda_pkg::RD_STATUS, 8'h00);
    send_op(dda_pkg::OP_READ, 5'h1F, 8'h00);
    send_op(dda_pkg::OP_WRITE, 5'h1F, 8'hFF);
    send_op(dda_pkg::OP_SELECT, '0, '0);
    send_op(dda_pkg::OP_INSERT, '0, '0);
    send_op(dda_pkg::OP_SELECT, '0, '0);
    send_word(make_word(dda_pkg::op_t'(3'd7), '0, '0));
    send_op(dda_pkg::OP_INSERT, '0, '0);
  endtask

  task automatic send_random(input int count);
    dda_pkg::item_t it;
    int k;
    for (int i = 0; i < count; i++) begin
      it = '0;
      it = dda_pkg::item_t'(54'({$urandom, $urandom}));
      k = $urandom_range(0, 99);
      if (k < 15) it.opcode = dda_pkg::OP_TICK;
      else if (k < 45) begin
        it.opcode = dda_pkg::OP_WRITE;
        if ($urandom_range(0, 9) != 0) it.reg_offset = 5'($urandom_range(0, 6));
      end else if (k < 75) begin
        it.opcode = dda_pkg::OP_READ;
        if ($urandom_range(0, 9) != 0) it.reg_offset = 5'($urandom_range(16, 19));
      end else if (k < 82) it.opcode = dda_pkg::OP_INSERT;
      else if (k < 88) it.opcode = dda_pkg::OP_SELECT;
      else if (k < 97) begin
        it.opcode = dda_pkg::OP_LOAD;
        if ($urandom_range(0, 3) != 0) it.load_addr = 16'($urandom_range(0, 40));
      end else it.opcode = 3'($urandom_range(6, 7));
      if (it.opcode == dda_pkg::OP_TICK && $urandom_range(0, 1))
        it.tick_cycles = 10'($urandom_range(0, 60));
      // keep disk reads on written bytes
      if (it.opcode == dda_pkg::OP_READ && it.reg_offset == dda_pkg::RD_DATA && m_present &&
          !image_known(m_ins_side, m_hpos))
        send_load(m_ins_side, m_hpos, 8'($urandom));
      send_word(it);
    end
  endtask

  task automatic test_random_phase(input logic [3:0] sides, input int count);
    write_side_count(sides);
    for (int sd = 0; sd < 4; sd++) fill_head_window(3'(sd), 42);
    send_random(count);
  endtask

  initial begin
    model_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_phase(4'd8, 160);
    test_random_phase(4'd0, 120);
    test_random_phase(4'd15, 120);
    test_random_phase(4'd3, 120);
    stall_en = 1'b0;
    test_random_phase(4'd1, 120);
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("tb_disk_drive_adapter_registers_top: done, clean");
    else
      $display("tb_disk_drive_adapter_registers_top: done, errors");
    $finish;
  end

endmodule
